@@ hdl/swt4r_pkg.sv @@
// ----------------------------------------------------------------------------
// swt4r_pkg - shared types and constants of the skinning weight reducer
// Holds the request and response beat layouts, the stored entry layout,
// the request codes and the controller states.
// ----------------------------------------------------------------------------
package swt4r_pkg;

   localparam int VERTEX_COUNT = 4096;
   localparam int BONE_COUNT   = 256;
   localparam int SLOTS        = 4;

   // The vertex field is 12 bits wide, so no entry at 4096 or above is reachable.
   localparam int MEM_DEPTH = (VERTEX_COUNT < 4096) ? VERTEX_COUNT : 4096;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [11:0] vertex_index;
      logic [7:0]  bone_index;
      logic [15:0] weight;
   } swt4r_req_type;

   typedef struct packed {
      logic [11:0] out_vertex;
      logic [2:0]  slot_count;
      logic [7:0]  bone_first;
      logic [7:0]  bone_second;
      logic [7:0]  bone_third;
      logic [7:0]  bone_fourth;
      logic [15:0] norm_first;
      logic [15:0] norm_second;
      logic [15:0] norm_third;
      logic [15:0] norm_fourth;
   } swt4r_rsp_type;

   // One vertex entry: slot 0 holds the largest weight.
   typedef struct packed {
      logic [2:0]       count;
      logic [3:0][7:0]  bones;
      logic [3:0][15:0] weights;
   } swt4r_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_LOAD,
      ST_RUN,
      ST_DONE
   } swt4r_state_type;

endpackage

@@ hdl/skin_weight_top4_reducer.sv @@
// ----------------------------------------------------------------------------
// skin_weight_top4_reducer - per-vertex top four bone weight reducer
// Keeps the four largest nonzero bone weights of every vertex in a
// single-port-read, single-port-write memory and reads them out normalized.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_data) is taken at a rising edge where start is high
//   and busy is low. An add beat inserts one bone influence into the sorted
//   list of its vertex; it produces no response and keeps busy high while
//   the entry is looked up and updated, so no new beat is taken before the
//   update. The memory is read at the accepting edge and the modified entry
//   is written back in the following cycle.
//   A read beat returns the bones and their normalized weights on rsp_data,
//   marked by rsp_valid for exactly one cycle, and clears the vertex. The
//   four quotients share one restoring divider that produces one quotient
//   bit a cycle, which sets the readout time. busy is already low in the
//   cycle where the response is shown, so the next request may be accepted
//   at the edge that ends it.
//   The receiver cannot stall; the response is simply gone after its cycle.
//   After reset the block sweeps the whole store to zero, one entry a cycle,
//   which keeps busy high until the last entry is cleared; only then is the
//   first request taken.
// ----------------------------------------------------------------------------
module skin_weight_top4_reducer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  swt4r_pkg::swt4r_req_type req_data,
   output logic                     rsp_valid,
   output swt4r_pkg::swt4r_rsp_type rsp_data
);
   import swt4r_pkg::*;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   swt4r_state_type  state_ff, state_in;
   logic [MEM_AW-1:0] clr_addr_ff, clr_addr_in;

   // Request captured at the accepting edge.
   logic              op_ff;
   logic [11:0]       vertex_ff;
   logic [7:0]        bone_ff;
   logic [15:0]       weight_ff;

   // Readout working set.
   logic [2:0]        cnt_ff, cnt_in;
   logic [3:0][7:0]   bones_ff, bones_in;
   logic [3:0][15:0]  weights_ff, weights_in;
   logic [17:0]       sum_ff, sum_in;
   logic [3:0][15:0]  norm_ff, norm_in;

   // Shared restoring divider.
   logic [1:0]        slot_ff, slot_in;
   logic [4:0]        step_ff, step_in;
   logic [17:0]       rem_ff, rem_in;
   logic [16:0]       num_ff, num_in;
   logic [16:0]       quo_ff, quo_in;

   logic              rsp_valid_ff, rsp_valid_in;
   swt4r_rsp_type     rsp_ff, rsp_in;

   // ------------------------------------------------------------------------
   // Vertex store: read at the accepting edge, written back in the following cycle.
   // ------------------------------------------------------------------------
   swt4r_entry_type   mem [MEM_DEPTH];
   swt4r_entry_type   rd_data_ff;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   swt4r_entry_type   mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[req_data.vertex_index[MEM_AW-1:0]];
   end

   logic accept;
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // ------------------------------------------------------------------------
   // Entry update for an add beat. The new weight goes in front of the first
   // strictly smaller kept weight, so an equal weight stays behind the older
   // one. A weight below all kept ones is appended while a slot is free.
   // ------------------------------------------------------------------------
   logic            vertex_ok;
   logic            add_ok;
   swt4r_entry_type ent;
   swt4r_entry_type ins;
   logic [2:0]      cnt_c;
   logic [2:0]      pos;
   logic [2:0]      last;
   logic            found;
   logic            add_write;
   logic [17:0]     sum_c;

   assign vertex_ok = ({5'b0, vertex_ff} < 17'(VERTEX_COUNT));
   assign add_ok    = (weight_ff != 16'd0) && vertex_ok
                      && ({1'b0, bone_ff} < 9'(BONE_COUNT));
   assign ent       = vertex_ok ? rd_data_ff : '0;

   always_comb begin
      cnt_c = (ent.count > 3'(SLOTS)) ? 3'(SLOTS) : ent.count;
      pos   = cnt_c;
      found = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (!found && (3'(k) < cnt_c) && (ent.weights[k] < weight_ff)) begin
            pos   = 3'(k);
            found = 1'b1;
         end
      end
      last = (cnt_c < 3'(SLOTS)) ? cnt_c : 3'(SLOTS - 1);

      ins = ent;
      for (int k = 1; k < 4; k++) begin
         if ((3'(k) > pos) && (3'(k) <= last)) begin
            ins.bones[k]   = ent.bones[k-1];
            ins.weights[k] = ent.weights[k-1];
         end
      end
      if (pos < 3'(SLOTS)) begin
         ins.bones[pos[1:0]]   = bone_ff;
         ins.weights[pos[1:0]] = weight_ff;
      end
      ins.count = (cnt_c < 3'(SLOTS)) ? cnt_c + 3'd1 : cnt_c;
      add_write = add_ok && (pos < 3'(SLOTS));

      sum_c = '0;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < cnt_c) begin
            sum_c = sum_c + {2'b0, ent.weights[k]};
         end
      end
   end

   // ------------------------------------------------------------------------
   // Divider step: quotient of (w << 16) / sum, one bit a cycle. Since the
   // weight never exceeds the sum, the quotient fits in 17 bits and the
   // start remainder w >> 1 is already below the divisor.
   // ------------------------------------------------------------------------
   logic [18:0] trial;
   logic        trial_ge;
   assign trial    = {rem_ff, num_ff[16]};
   assign trial_ge = (trial >= {1'b0, sum_ff});

   // ------------------------------------------------------------------------
   // Controller
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cnt_in       = cnt_ff;
      bones_in     = bones_ff;
      weights_in   = weights_ff;
      sum_in       = sum_ff;
      norm_in      = norm_ff;
      slot_in      = slot_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = vertex_ff[MEM_AW-1:0];
      mem_wdata    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + MEM_AW'(1);
            if (clr_addr_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (op_ff == REQ_ADD) begin
               mem_we    = add_write;
               mem_wdata = ins;
               state_in  = ST_IDLE;
            end else begin
               // Read out: keep the valid slots, clear the entry.
               mem_we = vertex_ok;
               cnt_in = cnt_c;
               sum_in = sum_c;
               for (int k = 0; k < 4; k++) begin
                  bones_in[k]   = (3'(k) < cnt_c) ? ent.bones[k] : 8'd0;
                  weights_in[k] = (3'(k) < cnt_c) ? ent.weights[k] : 16'd0;
               end
               slot_in  = 2'd0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rem_in   = {3'b0, weights_ff[slot_ff][15:1]};
            num_in   = {weights_ff[slot_ff][0], 16'd0};
            quo_in   = '0;
            step_in  = 5'd16;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rem_in  = trial_ge ? 18'(trial - {1'b0, sum_ff}) : trial[17:0];
            num_in  = {num_ff[15:0], 1'b0};
            quo_in  = {quo_ff[15:0], trial_ge};
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               // A quotient of exactly 65536 saturates.
               norm_in[slot_ff] = quo_ff[15] ? 16'hFFFF : {quo_ff[14:0], trial_ge};
               if (slot_ff == 2'd3) begin
                  state_in = ST_DONE;
               end else begin
                  slot_in  = slot_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.out_vertex  = vertex_ff;
            rsp_in.slot_count  = cnt_ff;
            rsp_in.bone_first  = bones_ff[0];
            rsp_in.bone_second = bones_ff[1];
            rsp_in.bone_third  = bones_ff[2];
            rsp_in.bone_fourth = bones_ff[3];
            // An empty vertex has a zero sum; its quotients mean nothing.
            rsp_in.norm_first  = (sum_ff == 18'd0) ? 16'd0 : norm_ff[0];
            rsp_in.norm_second = (sum_ff == 18'd0) ? 16'd0 : norm_ff[1];
            rsp_in.norm_third  = (sum_ff == 18'd0) ? 16'd0 : norm_ff[2];
            rsp_in.norm_fourth = (sum_ff == 18'd0) ? 16'd0 : norm_ff[3];
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.req_type;
         vertex_ff <= req_data.vertex_index;
         bone_ff   <= req_data.bone_index;
         weight_ff <= req_data.weight;
      end
      cnt_ff     <= cnt_in;
      bones_ff   <= bones_in;
      weights_ff <= weights_in;
      sum_ff     <= sum_in;
      norm_ff    <= norm_in;
      slot_ff    <= slot_in;
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // Every accepted beat is looked up in the store in the next cycle.
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted beat did not reach the lookup cycle");

   // An add beat never produces a response.
   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && op_ff == REQ_ADD) |=> ##1 !rsp_valid)
      else $error("add beat produced a response");

   // The block is ready again in the cycle that shows a response.
   a_rsp_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while a response is shown");

   // The divider remainder stays below the divisor while it runs.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && sum_ff != 18'd0) |-> (rem_ff < sum_ff))
      else $error("divider remainder out of range");

endmodule

@@ verif/skin_weight_top4_reducer_tb.sv @@
// ----------------------------------------------------------------------------
// skin_weight_top4_reducer_tb - self-checking bench of the top four reducer
// Drives add and read beats through the start/busy port and keeps its own
// per-vertex copy of the sorted influence lists. Every readout is checked
// field by field against that copy or a typed-in readout. A short directed
// table covers the corner cases, then constrained-by-hand random traffic
// fills a small pool of vertices so that lists overflow, tie and get read back.
// ----------------------------------------------------------------------------
module skin_weight_top4_reducer_tb;

   import swt4r_pkg::*;

   // A directed row: one request beat, plus a typed-in readout where the
   // answer is obvious enough to be written down by hand.
   typedef struct {
      swt4r_req_type beat;
      bit            pinned;
      swt4r_rsp_type golden;
   } plan_row_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   swt4r_req_type req_data;
   logic          rsp_valid;
   swt4r_rsp_type rsp_data;

   // The typed-in readout travels alongside the beat, so the monitor sees it
   // at the same edge at which the beat is taken.
   logic          pin_on;
   swt4r_rsp_type pin_rsp;

   // Bench copy of the store: kept bones and weights per vertex, largest
   // weight in slot 0, and the number of kept entries.
   bit [7:0]  vtx_bones   [VERTEX_COUNT][SLOTS];
   bit [15:0] vtx_weights [VERTEX_COUNT][SLOTS];
   int        vtx_fill    [VERTEX_COUNT];

   swt4r_rsp_type pending_readouts [$];
   plan_row_type  plan [$];

   int mismatches;
   int n_adds;
   int n_ignored;
   int n_reads;
   int n_checked;
   int n_full;
   bit no_idle;

   skin_weight_top4_reducer u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // -------------------------------------------------------------------------
   // Reporting
   // -------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [15:0] seen,
                                  input logic [15:0] wanted);
      $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, seen, wanted);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [15:0] seen,
                              input logic [15:0] wanted);
      if (seen !== wanted) report_mismatch(what, seen, wanted);
   endtask

   // Appends one expected readout at the tail of the queue.
   function automatic void queue_readout(input swt4r_rsp_type r);
      pending_readouts = {pending_readouts, r};
   endfunction

   // -------------------------------------------------------------------------
   // Predictor of the influence lists
   // -------------------------------------------------------------------------

   // Insert one influence behind every kept weight that is not smaller than
   // it. A weight below all kept ones is appended while a slot is free and
   // dropped once the list is full; a full list loses its last entry.
   function automatic void insert_influence(input logic [11:0] v, input logic [7:0] bone,
                                            input logic [15:0] w);
      int fill;
      int pos;
      int k;
      fill = vtx_fill[v];
      pos  = fill;
      for (k = 0; k < fill; k++) begin
         if (pos == fill && vtx_weights[v][k] < w) pos = k;
      end
      if (pos >= SLOTS) return;
      for (k = (fill < SLOTS) ? fill : SLOTS - 1; k > pos; k--) begin
         vtx_bones[v][k]   = vtx_bones[v][k - 1];
         vtx_weights[v][k] = vtx_weights[v][k - 1];
      end
      vtx_bones[v][pos]   = bone;
      vtx_weights[v][pos] = w;
      if (fill < SLOTS) vtx_fill[v] = fill + 1;
   endfunction

   // Build the readout of one vertex and empty it. Each weight is scaled as
   // floor(w * 65536 / total); a lone entry scales to 65536 and saturates.
   function automatic swt4r_rsp_type drain_vertex(input logic [11:0] v);
      swt4r_rsp_type r;
      logic [17:0]   total;
      logic [31:0]   quot;
      logic [7:0]    b [SLOTS];
      logic [15:0]   n [SLOTS];
      int            k;
      total = '0;
      for (k = 0; k < vtx_fill[v]; k++) total += vtx_weights[v][k];
      for (k = 0; k < SLOTS; k++) begin
         b[k] = '0;
         n[k] = '0;
         if (k < vtx_fill[v]) begin
            quot = {vtx_weights[v][k], 16'h0000} / total;
            n[k] = (quot > 32'd65535) ? 16'hFFFF : quot[15:0];
            b[k] = vtx_bones[v][k];
         end
      end
      r.out_vertex  = v;
      r.slot_count  = 3'(vtx_fill[v]);
      r.bone_first  = b[0];
      r.bone_second = b[1];
      r.bone_third  = b[2];
      r.bone_fourth = b[3];
      r.norm_first  = n[0];
      r.norm_second = n[1];
      r.norm_third  = n[2];
      r.norm_fourth = n[3];
      for (k = 0; k < SLOTS; k++) begin
         vtx_bones[v][k]   = '0;
         vtx_weights[v][k] = '0;
      end
      vtx_fill[v] = 0;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Monitor: takes request beats, predicts, and checks readouts
   // -------------------------------------------------------------------------

   task automatic check_readout(input swt4r_rsp_type got);
      swt4r_rsp_type want;
      if (pending_readouts.size() == 0) begin
         report_mismatch("readout with none pending, vertex", 16'(got.out_vertex), 16'd0);
      end else begin
         want = pending_readouts.pop_front();
         n_checked++;
         if (got.slot_count == 3'd4) n_full++;
         check_field("out_vertex", 16'(got.out_vertex), 16'(want.out_vertex));
         check_field("slot_count", 16'(got.slot_count), 16'(want.slot_count));
         check_field("bone_first", 16'(got.bone_first), 16'(want.bone_first));
         check_field("bone_second", 16'(got.bone_second), 16'(want.bone_second));
         check_field("bone_third", 16'(got.bone_third), 16'(want.bone_third));
         check_field("bone_fourth", 16'(got.bone_fourth), 16'(want.bone_fourth));
         check_field("norm_first", got.norm_first, want.norm_first);
         check_field("norm_second", got.norm_second, want.norm_second);
         check_field("norm_third", got.norm_third, want.norm_third);
         check_field("norm_fourth", got.norm_fourth, want.norm_fourth);
      end
   endtask

   // Everything here reads values from before the edge: the block updates its
   // outputs and the driver its inputs with nonblocking assignments. A readout
   // shown in the same cycle as a new beat is taken belongs to an older read,
   // so it is checked before the new expectation joins the queue.
   always @(posedge clock) begin
      swt4r_rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) check_readout(rsp_data);
         else if (rsp_valid !== 1'b0)
            report_mismatch("rsp_valid unknown", 16'(rsp_valid), 16'd0);
         if (start === 1'b1 && busy === 1'b0) begin
            if (req_data.req_type == REQ_READ) begin
               want = drain_vertex(req_data.vertex_index);
               queue_readout(pin_on ? pin_rsp : want);
               n_reads++;
            end else if (req_data.weight != '0) begin
               insert_influence(req_data.vertex_index, req_data.bone_index, req_data.weight);
               n_adds++;
            end else begin
               n_ignored++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver helpers
   // -------------------------------------------------------------------------

   // Mostly back to back, sometimes a few cycles, rarely a long pause.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   // Called at a rising edge; returns at the edge that takes the beat, with
   // start still high so that a following beat can go out without a gap.
   task automatic send_beat(input swt4r_req_type beat, input bit pinned,
                            input swt4r_rsp_type golden, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      pin_on   <= pinned;
      pin_rsp  <= golden;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic plan_beat(input logic kind, input int v, input int b, input int w);
      plan_row_type row;
      row.beat.req_type     = kind;
      row.beat.vertex_index = 12'(v);
      row.beat.bone_index   = 8'(b);
      row.beat.weight       = 16'(w);
      row.pinned            = 1'b0;
      row.golden            = '0;
      plan = {plan, row};
   endtask

   // A read whose readout is written down here: only the first slot is used.
   task automatic plan_read_pinned(input int v, input int cnt, input int b, input int n);
      plan_row_type row;
      row.beat              = '0;
      row.beat.req_type     = REQ_READ;
      row.beat.vertex_index = 12'(v);
      row.pinned            = 1'b1;
      row.golden            = '0;
      row.golden.out_vertex = 12'(v);
      row.golden.slot_count = 3'(cnt);
      row.golden.bone_first = 8'(b);
      row.golden.norm_first = 16'(n);
      plan = {plan, row};
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   initial begin
      swt4r_req_type beat;
      logic [11:0]   pool [16];
      int            counted;
      int            sent;
      int            roll;
      int            drain_cycles;
      bit            counts;

      mismatches = 0;
      n_adds     = 0;
      n_ignored  = 0;
      n_reads    = 0;
      n_checked  = 0;
      n_full     = 0;
      no_idle    = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      pin_on     = 1'b0;
      pin_rsp    = '0;
      for (int v = 0; v < VERTEX_COUNT; v++) vtx_fill[v] = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block sweeps its store after reset; send_beat
      // simply waits for busy to drop.
      plan_read_pinned(0, 0, 0, 0);             // empty vertex at the low end
      plan_read_pinned(4095, 0, 0, 0);          // empty vertex at the high end
      plan_beat(REQ_ADD, 4095, 255, 65535);
      plan_read_pinned(4095, 1, 255, 65535);    // lone entry saturates the scale
      plan_beat(REQ_ADD, 5, 1, 0);              // zero weight is dropped
      plan_read_pinned(5, 0, 0, 0);
      plan_beat(REQ_ADD, 10, 3, 100);
      plan_beat(REQ_ADD, 10, 4, 300);
      plan_beat(REQ_ADD, 10, 5, 200);
      plan_beat(REQ_ADD, 10, 6, 300);           // tie stays behind the older one
      plan_beat(REQ_ADD, 10, 7, 50);            // below a full list: lost
      plan_beat(REQ_ADD, 10, 8, 250);           // pushes the smallest off the end
      plan_beat(REQ_READ, 10, 0, 0);
      plan_read_pinned(10, 0, 0, 0);            // the read cleared the vertex
      plan_beat(REQ_ADD, 20, 9, 1000);
      plan_beat(REQ_ADD, 20, 9, 1000);          // same bone twice, two entries
      plan_beat(REQ_ADD, 20, 0, 1);             // smallest weight is appended
      plan_beat(REQ_READ, 20, 255, 65535);      // bone and weight ignored on read
      plan_beat(REQ_ADD, 30, 2, 500);
      plan_beat(REQ_ADD, 30, 3, 100);
      plan_beat(REQ_READ, 30, 0, 0);
      plan_beat(REQ_ADD, 40, 128, 65535);
      plan_beat(REQ_ADD, 40, 127, 65535);
      plan_beat(REQ_READ, 40, 0, 0);

      foreach (plan[i]) send_beat(plan[i].beat, plan[i].pinned, plan[i].golden, pick_gap());

      // Random part. Most traffic lands on a small pool of vertices so that
      // lists fill up, overflow and tie before they are read back; the rest
      // scatters over the whole store and mostly reads empty vertices.
      pool[0] = 12'd0;
      pool[1] = 12'd4095;
      for (int i = 2; i < 16; i++) pool[i] = 12'($urandom_range(0, VERTEX_COUNT - 1));

      counted = 0;
      sent    = 0;
      while (counted < 1100) begin
         // Every 64 beats decide whether the next stretch runs without gaps.
         if (sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);

         beat.req_type     = ($urandom_range(0, 99) < 15) ? REQ_READ : REQ_ADD;
         beat.vertex_index = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 15)]
                                                          : 12'($urandom_range(0, 4095));
         beat.bone_index   = 8'($urandom_range(0, 255));
         roll = $urandom_range(0, 9);
         case (roll)
            0, 1, 2, 3: beat.weight = 16'($urandom_range(1, 65535));
            4, 5:       beat.weight = 16'($urandom_range(1, 16));
            6, 7:       beat.weight = 16'(1000 * $urandom_range(1, 4));  // ties
            8:          beat.weight = 16'hFFFF;
            default:    beat.weight = 16'h0000;
         endcase

         counts = (beat.req_type == REQ_READ) || (beat.weight != '0);
         if (counts) counted++;
         send_beat(beat, 1'b0, '0, pick_gap());
         sent++;

         // Now and then hold the sender until every readout is back.
         if (counts && counted % 300 == 150) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_readouts.size() != 0) @(posedge clock);
         end
      end

      // Let the last readouts arrive, then watch for strays a little longer
      // than one readout takes.
      start <= 1'b0;
      drain_cycles = 0;
      @(posedge clock);
      while (pending_readouts.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (100) @(posedge clock);
      while (pending_readouts.size() != 0) begin
         report_mismatch("readout never seen, vertex", 16'(pending_readouts[0].out_vertex),
                         16'd0);
         void'(pending_readouts.pop_front());
      end

      $display("Sent %0d add beats (%0d zero-weight ones dropped) and %0d read beats.",
               n_adds, n_ignored, n_reads);
      $display("Compared %0d readouts, %0d of them with all four slots in use.",
               n_checked, n_full);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, clearing sweep included.
   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule
